### sv/sc1_pkg.sv
// Shared types, codes and key lookup tables for the scan code set 1 decoder.
package sc1_pkg;

    localparam int unsigned SCAN_W = 8;
    localparam int unsigned KEY_W  = 7;

    localparam logic [SCAN_W-1:0] PREFIX_EXT    = 8'hE0;
    localparam logic [SCAN_W-1:0] PREFIX_PAUSE  = 8'hE1;
    localparam logic [SCAN_W-1:0] FAKE_LSHIFT   = 8'h2A;
    localparam logic [SCAN_W-1:0] FAKE_RSHIFT   = 8'h36;
    localparam logic [SCAN_W-1:0] PAUSE_BYTE_LO = 8'h1D;
    localparam logic [SCAN_W-1:0] PAUSE_BYTE_HI = 8'h45;
    localparam logic [KEY_W-1:0]  KEY_NONE      = 7'd0;
    localparam logic [KEY_W-1:0]  KEY_PAUSE     = 7'd119;

    typedef enum logic [1:0] {
        PAUSE_IDLE   = 2'd0,
        PAUSE_FIRST  = 2'd1,
        PAUSE_SECOND = 2'd2
    } pause_stage_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             is_release;
        logic             drop;       // fake shift: no transaction
    } sc1_result_t;

    function automatic logic [KEY_W-1:0] lookup_normal(input logic [SCAN_W-1:0] code);
        logic [KEY_W-1:0] key;
        key = KEY_NONE;
        if (code <= 8'd82) begin
            key = code[KEY_W-1:0];
        end else if (code == 8'd83) begin
            key = 7'd84;
        end else if (code >= 8'd86 && code <= 8'd88) begin
            key = code[KEY_W-1:0];
        end
        return key;
    endfunction

    function automatic logic [KEY_W-1:0] lookup_extended(input logic [SCAN_W-1:0] code);
        logic [KEY_W-1:0] key;
        unique case (code)
            8'd28:   key = 7'd96;
            8'd29:   key = 7'd97;
            8'd53:   key = 7'd99;
            8'd56:   key = 7'd100;
            8'd71:   key = 7'd102;
            8'd72:   key = 7'd103;
            8'd73:   key = 7'd104;
            8'd75:   key = 7'd105;
            8'd77:   key = 7'd106;
            8'd79:   key = 7'd107;
            8'd80:   key = 7'd108;
            8'd81:   key = 7'd109;
            8'd82:   key = 7'd110;
            8'd83:   key = 7'd111;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

### sv/sc1_decode.sv
// Prefix tracking state and combinational decode of one scan code byte.
module sc1_decode (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sc1_pkg::SCAN_W-1:0]  scan_byte,
    input  logic                        advance,   // byte leaves the input register
    output sc1_pkg::sc1_result_t        result
);
    import sc1_pkg::*;

    logic           ext_reg, ext_next;
    pause_stage_t   stage_reg, stage_next;
    logic [SCAN_W-1:0] first_reg, first_next;

    pause_stage_t   stage;
    logic           brk;
    logic [SCAN_W-1:0] code;

    always_comb begin
        unique case (stage_reg)
            PAUSE_FIRST:  stage = PAUSE_FIRST;
            PAUSE_SECOND: stage = PAUSE_SECOND;
            default:      stage = PAUSE_IDLE;
        endcase

        // bit 7 is a break mark unless the byte is a fresh prefix
        brk = scan_byte[SCAN_W-1]
              && (stage != PAUSE_IDLE || scan_byte != PREFIX_PAUSE)
              && (ext_reg || scan_byte != PREFIX_EXT);
        code = brk ? {1'b0, scan_byte[SCAN_W-2:0]} : scan_byte;

        result.key_code   = KEY_NONE;
        result.is_release = brk;
        result.drop       = 1'b0;
        ext_next          = ext_reg;
        stage_next        = stage;
        first_next        = first_reg;

        if (ext_reg) begin
            ext_next = 1'b0;
            if (code == FAKE_LSHIFT || code == FAKE_RSHIFT) begin
                result.drop = 1'b1;
            end else begin
                result.key_code = lookup_extended(code);
            end
        end else if (stage == PAUSE_SECOND) begin
            if (code == PAUSE_BYTE_HI && first_reg == PAUSE_BYTE_LO) begin
                result.key_code = KEY_PAUSE;
            end
            stage_next = PAUSE_IDLE;
        end else if (stage == PAUSE_FIRST) begin
            first_next = code;
            stage_next = PAUSE_SECOND;
        end else if (code == PREFIX_EXT) begin
            ext_next = 1'b1;
        end else if (code == PREFIX_PAUSE) begin
            stage_next = PAUSE_FIRST;
        end else begin
            result.key_code = lookup_normal(code);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg   <= 1'b0;
            stage_reg <= PAUSE_IDLE;
            first_reg <= '0;
        end else if (advance) begin
            ext_reg   <= ext_next;
            stage_reg <= stage_next;
            first_reg <= first_next;
        end
    end

endmodule

### sv/scancode_set1_decoder.sv
// Top level: input register, set 1 decode and result register of the scan code decoder.
// Takes one scan code set 1 byte per transaction and returns a key code plus a release
// flag, one result per byte except for the fake shift bytes after an E0 prefix, which
// give none. Each byte is held in the input register, where the prefix state and the
// table lookups are evaluated, and then sits in the result register until taken; a new
// byte is accepted every cycle as long as the result side keeps draining, so throughput
// is one byte per cycle.
module scancode_set1_decoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] scan_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [6:0] key_code, [7] zero
    output logic                       m_tuser    // [0] is_release
);
    import sc1_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [SCAN_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_rel_reg;
    logic              advance;
    logic              load_out;
    sc1_result_t       result;

    sc1_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_byte (in_byte_reg),
        .advance   (advance),
        .result    (result)
    );

    // a dropped byte needs no room in the result register
    assign advance  = in_valid_reg && (result.drop || !out_valid_reg || m_tready);
    assign load_out = advance && !result.drop;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (load_out) begin
            out_key_reg <= result.key_code;
            out_rel_reg <= result.is_release;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_key_reg};
    assign m_tuser  = out_rel_reg;

endmodule
